// ===== design/dcd_pkg.sv =====
// Shared types and codes for the delta command decoder.
// Holds the port word structs, the queue word between front and back, and the codes.
// No dependencies.
`default_nettype none

package dcd_pkg;

    // Depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_COPY    = 2'd0;
    localparam logic [1:0] KIND_INSERT  = 2'd1;
    localparam logic [1:0] KIND_LITERAL = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_CMD   = 3'd1;
    localparam logic [2:0] ST_BEYOND     = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_MISMATCH   = 3'd4;
    localparam logic [2:0] ST_HDR_OVERFL = 3'd5;

    // Operations handed from the front to the back
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_SET_BASE   = 3'd1;
    localparam logic [2:0] OP_SET_TARGET = 3'd2;
    localparam logic [2:0] OP_COPY       = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;
    localparam logic [2:0] OP_LITERAL    = 3'd5;
    localparam logic [2:0] OP_ERROR      = 3'd6;

    // Copy size that an all-zero size field stands for
    localparam logic [23:0] COPY_SIZE_DEFAULT = 24'h010000;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_last;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_offset;
        logic [23:0] chunk_size;
        logic [31:0] source_offset;
        logic [7:0]  literal;
        logic        stream_end;
        logic [2:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;      // header value or copy source offset
        logic [23:0] size;       // copy size or insert length
        logic [7:0]  literal;
        logic [2:0]  code;       // error code for OP_ERROR
        logic        last;
        logic        truncated;  // stream ends inside a header, operands or literals
    } cmd_word_t;

endpackage

`default_nettype wire

// ===== design/delta_command_decoder_top.sv =====
// Delta command decoder: one stream byte per cycle in, at most one result word per byte out.
// The front parses a byte and pushes its word into the queue at the edge that accepts it;
// the back checks the queue's head word and loads the output register when it pops that word.
// Throughput: one byte every cycle; the input stalls only while the queue is full, which
// takes a held output word and four queued words. The back's 33-bit add and compare sets the
// clock path. Reset (rst_n, asynchronous, active low) clears parser, queue, sizes and status.
`default_nettype none

module delta_command_decoder_top #(
    parameter int QUEUE_DEPTH = dcd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire dcd_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output dcd_pkg::out_word_t     out_data
);
    import dcd_pkg::*;

    // Words from the front parser towards the queue
    logic      push;
    cmd_word_t push_word;
    logic      queue_full;

    // Words from the queue towards the back
    logic      q_pop;
    logic      q_not_empty;
    cmd_word_t q_word;

    // Front: hold the in channel while the queue is full, otherwise take one byte a cycle,
    // parse the size headers and commands, and push a word for every byte that matters.
    dcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    // Queue: decouple parsing from result delivery so a stalled consumer
    // does not stop the parser until the queue fills.
    dcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (queue_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_word  (q_word)
    );

    // Back: check each chunk against base and target sizes, track bytes written,
    // latch the first error and drop later chunks until the stream's last word.
    dcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

// ===== design/dcd_front.sv =====
// Front of the delta command decoder: accepts stream bytes, parses headers and commands.
// Pushes one command word per meaningful byte into the queue. Depends on dcd_pkg.
`default_nettype none

module dcd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire dcd_pkg::in_word_t in_data,
    input  wire logic             queue_full,
    output logic                  push,
    output dcd_pkg::cmd_word_t    push_word
);
    import dcd_pkg::*;

    localparam logic [2:0] PH_BASE   = 3'd0;
    localparam logic [2:0] PH_TARGET = 3'd1;
    localparam logic [2:0] PH_CMD    = 3'd2;
    localparam logic [2:0] PH_COPY   = 3'd3;
    localparam logic [2:0] PH_LIT    = 3'd4;
    localparam logic [2:0] PH_ERR    = 3'd5;

    localparam logic [5:0] SHIFT_STEP = 6'd7;
    localparam logic [5:0] SHIFT_TOP  = 6'd28;
    localparam logic [5:0] SHIFT_MAX  = 6'd35;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] hdr_acc_reg, hdr_acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic [6:0]  mask_reg, mask_next;
    logic [31:0] off_acc_reg, off_acc_next;
    logic [23:0] size_acc_reg, size_acc_next;
    logic [6:0]  lit_rem_reg, lit_rem_next;

    logic        accept;
    logic        produce;
    logic [6:0]  bits;
    logic [31:0] hdr_merged;
    logic [6:0]  low_bit;
    logic [7:0]  b;
    cmd_word_t   word;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign b        = in_data.stream_byte;
    assign bits     = b[6:0];
    assign hdr_merged = hdr_acc_reg | ({25'd0, bits} << shift_reg);
    assign low_bit  = mask_reg & (~mask_reg + 7'd1);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_acc_next  = hdr_acc_reg;
        shift_next    = shift_reg;
        mask_next     = mask_reg;
        off_acc_next  = off_acc_reg;
        size_acc_next = size_acc_reg;
        lit_rem_next  = lit_rem_reg;
        produce       = 1'b0;
        word          = '0;
        word.op       = OP_NONE;

        case (phase_reg)
            PH_BASE, PH_TARGET:
            begin
                if (shift_reg >= SHIFT_MAX || (shift_reg == SHIFT_TOP && bits[6:4] != 3'd0))
                begin
                    produce     = 1'b1;
                    word.op     = OP_ERROR;
                    word.code   = ST_HDR_OVERFL;
                    phase_next  = PH_ERR;
                end
                else
                begin
                    hdr_acc_next = hdr_merged;
                    shift_next   = shift_reg + SHIFT_STEP;
                    if (!b[7])
                    begin
                        produce      = 1'b1;
                        word.op      = (phase_reg == PH_BASE) ? OP_SET_BASE : OP_SET_TARGET;
                        word.value   = hdr_merged;
                        hdr_acc_next = '0;
                        shift_next   = '0;
                        phase_next   = (phase_reg == PH_BASE) ? PH_TARGET : PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                if (b[7])
                begin
                    mask_next     = bits;
                    off_acc_next  = '0;
                    size_acc_next = '0;
                    if (bits == 7'd0)
                    begin
                        produce    = 1'b1;
                        word.op    = OP_COPY;
                        word.value = '0;
                        word.size  = COPY_SIZE_DEFAULT;
                    end
                    else
                    begin
                        phase_next = PH_COPY;
                    end
                end
                else if (b != 8'd0)
                begin
                    produce      = 1'b1;
                    word.op      = OP_INSERT;
                    word.size    = {17'd0, bits};
                    lit_rem_next = bits;
                    phase_next   = PH_LIT;
                end
                else
                begin
                    produce    = 1'b1;
                    word.op    = OP_ERROR;
                    word.code  = ST_ZERO_CMD;
                    phase_next = PH_ERR;
                end
            end
            PH_COPY:
            begin
                // Place the byte at the lowest selected operand position
                if (low_bit[0]) off_acc_next[7:0]    = off_acc_reg[7:0]    | b;
                if (low_bit[1]) off_acc_next[15:8]   = off_acc_reg[15:8]   | b;
                if (low_bit[2]) off_acc_next[23:16]  = off_acc_reg[23:16]  | b;
                if (low_bit[3]) off_acc_next[31:24]  = off_acc_reg[31:24]  | b;
                if (low_bit[4]) size_acc_next[7:0]   = size_acc_reg[7:0]   | b;
                if (low_bit[5]) size_acc_next[15:8]  = size_acc_reg[15:8]  | b;
                if (low_bit[6]) size_acc_next[23:16] = size_acc_reg[23:16] | b;
                mask_next = mask_reg & ~low_bit;
                if (mask_next == 7'd0)
                begin
                    produce    = 1'b1;
                    word.op    = OP_COPY;
                    word.value = off_acc_next;
                    word.size  = (size_acc_next == 24'd0) ? COPY_SIZE_DEFAULT : size_acc_next;
                    phase_next = PH_CMD;
                end
            end
            PH_LIT:
            begin
                produce      = 1'b1;
                word.op      = OP_LITERAL;
                word.literal = b;
                lit_rem_next = lit_rem_reg - 7'd1;
                if (lit_rem_reg == 7'd1)
                begin
                    phase_next = PH_CMD;
                end
            end
            default:
            begin
                // Error wait: drop bytes until the last one
            end
        endcase

        word.last      = in_data.stream_last;
        word.truncated = (phase_next != PH_CMD);

        // The last byte always carries a word and returns the parser to its reset state
        if (in_data.stream_last)
        begin
            produce       = 1'b1;
            phase_next    = PH_BASE;
            hdr_acc_next  = '0;
            shift_next    = '0;
            mask_next     = '0;
            off_acc_next  = '0;
            size_acc_next = '0;
            lit_rem_next  = '0;
        end
    end

    assign push      = accept && produce;
    assign push_word = word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_BASE;
            hdr_acc_reg  <= '0;
            shift_reg    <= '0;
            mask_reg     <= '0;
            off_acc_reg  <= '0;
            size_acc_reg <= '0;
            lit_rem_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hdr_acc_reg  <= hdr_acc_next;
            shift_reg    <= shift_next;
            mask_reg     <= mask_next;
            off_acc_reg  <= off_acc_next;
            size_acc_reg <= size_acc_next;
            lit_rem_reg  <= lit_rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dcd_queue.sv =====
// Short first-in first-out queue of command words between front and back.
// Depends on dcd_pkg.
`default_nettype none

module dcd_queue #(
    parameter int DEPTH = dcd_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dcd_pkg::cmd_word_t push_word,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output dcd_pkg::cmd_word_t      head_word
);
    import dcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    cmd_word_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_word = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dcd_back.sv =====
// Back of the delta command decoder: checks chunks against the header sizes and emits results.
// Tracks bytes written and the error status, drives the output register. Depends on dcd_pkg.
`default_nettype none

module dcd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_not_empty,
    input  wire dcd_pkg::cmd_word_t q_word,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dcd_pkg::out_word_t      out_data
);
    import dcd_pkg::*;

    logic [31:0] base_reg, base_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] written_reg, written_next;
    logic [31:0] lit_pos_reg, lit_pos_next;
    logic [2:0]  err_reg, err_next;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic [23:0] size_sel;
    logic [32:0] fill_sum;
    logic [32:0] src_end;
    logic [31:0] target_eff;
    logic        over_base;
    logic        over_target;
    logic        fill_eq;
    logic [2:0]  err_new;
    logic        have;
    out_word_t   result;

    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    assign size_sel    = (q_word.op inside {OP_COPY, OP_INSERT}) ? q_word.size : '0;
    assign fill_sum    = {1'b0, written_reg} + {9'd0, size_sel};
    assign src_end     = {1'b0, q_word.value} + {9'd0, q_word.size};
    assign over_base   = src_end > {1'b0, base_reg};
    assign over_target = fill_sum > {1'b0, target_reg};
    assign target_eff  = (q_word.op == OP_SET_TARGET) ? q_word.value : target_reg;
    assign fill_eq     = (fill_sum == {1'b0, target_eff});

    always_comb
    begin
        base_next    = base_reg;
        target_next  = target_reg;
        written_next = written_reg;
        lit_pos_next = lit_pos_reg;
        err_next     = err_reg;
        err_new      = ST_OK;
        have         = 1'b0;
        result       = '0;

        if (err_reg == ST_OK)
        begin
            case (q_word.op)
                OP_SET_BASE:
                begin
                    base_next = q_word.value;
                end
                OP_SET_TARGET:
                begin
                    target_next = q_word.value;
                end
                OP_COPY:
                begin
                    if (over_base)
                    begin
                        err_new = ST_BEYOND;
                    end
                    else if (over_target)
                    begin
                        err_new = ST_MISMATCH;
                    end
                    else
                    begin
                        have                 = 1'b1;
                        result.kind          = KIND_COPY;
                        result.target_offset = written_reg;
                        result.chunk_size    = q_word.size;
                        result.source_offset = q_word.value;
                        written_next         = fill_sum[31:0];
                    end
                end
                OP_INSERT:
                begin
                    if (over_target)
                    begin
                        err_new = ST_MISMATCH;
                    end
                    else
                    begin
                        have                 = 1'b1;
                        result.kind          = KIND_INSERT;
                        result.target_offset = written_reg;
                        result.chunk_size    = q_word.size;
                        written_next         = fill_sum[31:0];
                        lit_pos_next         = written_reg;
                    end
                end
                OP_LITERAL:
                begin
                    have                 = 1'b1;
                    result.kind          = KIND_LITERAL;
                    result.target_offset = lit_pos_reg;
                    result.literal       = q_word.literal;
                    lit_pos_next         = lit_pos_reg + 32'd1;
                end
                OP_ERROR:
                begin
                    err_new = q_word.code;
                end
                default:
                begin
                end
            endcase
        end

        if (err_new != ST_OK)
        begin
            have          = 1'b1;
            result        = '0;
            result.kind   = KIND_END;
            result.status = err_new;
            err_next      = err_new;
        end

        if (q_word.last)
        begin
            if (!have)
            begin
                result      = '0;
                result.kind = KIND_END;
            end
            have              = 1'b1;
            result.stream_end = 1'b1;
            if (err_next != ST_OK)
            begin
                result.status = err_next;
            end
            else if (q_word.truncated)
            begin
                result.status = ST_TRUNCATED;
            end
            else if (!fill_eq)
            begin
                result.status = ST_MISMATCH;
            end
            else
            begin
                result.status = ST_OK;
            end
            base_next    = '0;
            target_next  = '0;
            written_next = '0;
            lit_pos_next = '0;
            err_next     = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            target_reg    <= '0;
            written_reg   <= '0;
            lit_pos_reg   <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                base_reg    <= base_next;
                target_reg  <= target_next;
                written_reg <= written_next;
                lit_pos_reg <= lit_pos_next;
                err_reg     <= err_next;
            end
            if (q_pop && have)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && have)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
